[rtl/lpde_pkg.sv]
// ----------------------------------------------------------------------------
// lpde_pkg
// Shared constants and types of the line program delta encoder: field widths,
// line program opcodes, LEB128 constants and the back end state type.
// ----------------------------------------------------------------------------
package lpde_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH          = 32;
   localparam int BYTE_WIDTH           = 8;
   localparam int LEB_DATA_BITS        = 7;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   localparam logic [BYTE_WIDTH-1:0] OP_COPY         = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] OP_ADVANCE_PC   = 8'h02;
   localparam logic [BYTE_WIDTH-1:0] OP_ADVANCE_LINE = 8'h03;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PC_OP,
      ST_PC_LEB,
      ST_LINE_OP,
      ST_LINE_LEB,
      ST_COPY
   } back_state_type;

endpackage

[rtl/lpde_if.sv]
// ----------------------------------------------------------------------------
// lpde_if
// Valid/ready channels of the encoder: the mapping request channel and the
// encoded byte response channel.
// ----------------------------------------------------------------------------
interface lpde_req_if import lpde_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] source_offset;
   logic [FIELD_WIDTH-1:0] dest_offset;

   modport source (output valid, output source_offset, output dest_offset, input ready);
   modport sink (input valid, input source_offset, input dest_offset, output ready);
endinterface

interface lpde_rsp_if import lpde_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] out_byte;
   logic                  last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

[rtl/lpde_front.sv]
// ----------------------------------------------------------------------------
// lpde_front
// Accepts mapping requests, forms the wrapped offset differences against the
// previous mapping and pushes one command per request into the queue.
// ----------------------------------------------------------------------------
module lpde_front import lpde_pkg::*; #(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT,
   localparam int CMD_WIDTH   = 2 * OFFSET_WIDTH + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   lpde_req_if.sink             req,
   input  logic                 queue_full,
   output logic                 push,
   output logic [CMD_WIDTH-1:0] push_data
);

   logic [OFFSET_WIDTH-1:0] prev_src_ff, prev_src_in;
   logic [OFFSET_WIDTH-1:0] prev_dst_ff, prev_dst_in;
   logic [OFFSET_WIDTH-1:0] src, dst;
   logic [OFFSET_WIDTH-1:0] src_diff, dst_diff;
   logic                    src_chg, dst_chg;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   assign src      = OFFSET_WIDTH'(req.source_offset);
   assign dst      = OFFSET_WIDTH'(req.dest_offset);
   assign src_diff = src - prev_src_ff;
   assign dst_diff = dst - prev_dst_ff;
   assign src_chg  = src != prev_src_ff;
   assign dst_chg  = dst != prev_dst_ff;

   assign push_data = {dst_chg, src_chg, dst_diff, src_diff};

   assign prev_src_in = push ? src : prev_src_ff;
   assign prev_dst_in = push ? dst : prev_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_src_ff <= '0;
         prev_dst_ff <= '0;
      end else begin
         prev_src_ff <= prev_src_in;
         prev_dst_ff <= prev_dst_in;
      end
   end

endmodule

[rtl/lpde_fifo.sv]
// ----------------------------------------------------------------------------
// lpde_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lpde_fifo import lpde_pkg::*; #(
   parameter int WIDTH = 2 * OFFSET_WIDTH_DEFAULT + 2,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_WIDTH = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]     entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_WIDTH'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/lpde_back.sv]
// ----------------------------------------------------------------------------
// lpde_back
// Pops commands and emits the opcode and LEB128 bytes one per cycle, while the
// response channel is not stalled, through an output register.
// ----------------------------------------------------------------------------
module lpde_back import lpde_pkg::*; #(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT,
   localparam int CMD_WIDTH   = 2 * OFFSET_WIDTH + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  logic [CMD_WIDTH-1:0] pop_data,
   output logic                 pop,
   lpde_rsp_if.source           rsp
);

   back_state_type          state_ff, state_in;
   logic [OFFSET_WIDTH-1:0] leb_ff, leb_in;
   logic [OFFSET_WIDTH-1:0] src_diff_ff, src_diff_in;
   logic                    src_chg_ff, src_chg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_WIDTH-1:0]   out_byte_ff, out_byte_in;
   logic                    last_byte_ff, last_byte_in;

   logic                    cmd_dst_chg, cmd_src_chg;
   logic [OFFSET_WIDTH-1:0] cmd_dst_diff, cmd_src_diff;
   logic                    adv;
   logic [OFFSET_WIDTH-1:0] shift_u, shift_s;
   logic                    more_u, more_s;
   logic                    emit;
   logic [BYTE_WIDTH-1:0]   emit_byte;
   logic                    emit_last;

   assign cmd_dst_chg  = pop_data[2*OFFSET_WIDTH+1];
   assign cmd_src_chg  = pop_data[2*OFFSET_WIDTH];
   assign cmd_dst_diff = pop_data[2*OFFSET_WIDTH-1:OFFSET_WIDTH];
   assign cmd_src_diff = pop_data[OFFSET_WIDTH-1:0];

   assign adv     = !rsp_valid_ff || rsp.ready;
   assign shift_u = leb_ff >> LEB_DATA_BITS;
   assign shift_s = OFFSET_WIDTH'($signed(leb_ff) >>> LEB_DATA_BITS);
   assign more_u  = shift_u != '0;
   assign more_s  = !((shift_s == '0 && !leb_ff[LEB_DATA_BITS-1]) ||
                      (shift_s == '1 && leb_ff[LEB_DATA_BITS-1]));

   always_comb begin
      state_in    = state_ff;
      leb_in      = leb_ff;
      src_diff_in = src_diff_ff;
      src_chg_in  = src_chg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               src_diff_in = cmd_src_diff;
               src_chg_in  = cmd_src_chg;
               leb_in      = cmd_dst_chg ? cmd_dst_diff : cmd_src_diff;
               if (cmd_dst_chg) begin
                  state_in = ST_PC_OP;
               end else if (cmd_src_chg) begin
                  state_in = ST_LINE_OP;
               end else begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_PC_OP: begin
            if (adv) begin
               state_in = ST_PC_LEB;
            end
         end
         ST_PC_LEB: begin
            if (adv) begin
               if (more_u) begin
                  leb_in = shift_u;
               end else begin
                  leb_in   = src_diff_ff;
                  state_in = src_chg_ff ? ST_LINE_OP : ST_COPY;
               end
            end
         end
         ST_LINE_OP: begin
            if (adv) begin
               state_in = ST_LINE_LEB;
            end
         end
         ST_LINE_LEB: begin
            if (adv) begin
               if (more_s) begin
                  leb_in = shift_s;
               end else begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (adv) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_byte = OP_COPY;
      emit_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: pop = !queue_empty;
         ST_PC_OP: begin
            emit      = 1'b1;
            emit_byte = OP_ADVANCE_PC;
         end
         ST_PC_LEB: begin
            emit      = 1'b1;
            emit_byte = {more_u, leb_ff[LEB_DATA_BITS-1:0]};
         end
         ST_LINE_OP: begin
            emit      = 1'b1;
            emit_byte = OP_ADVANCE_LINE;
         end
         ST_LINE_LEB: begin
            emit      = 1'b1;
            emit_byte = {more_s, leb_ff[LEB_DATA_BITS-1:0]};
         end
         ST_COPY: begin
            emit      = 1'b1;
            emit_byte = OP_COPY;
            emit_last = 1'b1;
         end
         default: emit = 1'b0;
      endcase
   end

   assign rsp_valid_in = adv ? emit : rsp_valid_ff;
   assign out_byte_in  = (adv && emit) ? emit_byte : out_byte_ff;
   assign last_byte_in = (adv && emit) ? emit_last : last_byte_ff;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_byte  = out_byte_ff;
   assign rsp.last_byte = last_byte_ff;

   always_ff @(posedge clock) begin
      leb_ff       <= leb_in;
      src_diff_ff  <= src_diff_in;
      src_chg_ff   <= src_chg_in;
      out_byte_ff  <= out_byte_in;
      last_byte_ff <= last_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/line_program_delta_encoder.sv]
// ----------------------------------------------------------------------------
// line_program_delta_encoder
// A request's first byte passes the queue, the back end state register and
// the output register. The back end serializer emits a request's bytes before
// popping the next; the default two-entry queue lets requests arrive ahead.
// Reset: previous offsets clear to zero, queue empties, no response pending.
// ----------------------------------------------------------------------------
module line_program_delta_encoder import lpde_pkg::*; #(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lpde_req_if.sink    req_bus,
   lpde_rsp_if.source  rsp_bus
);

   localparam int CMD_WIDTH = 2 * OFFSET_WIDTH + 2;

   logic                 push, pop;
   logic [CMD_WIDTH-1:0] push_data, pop_data;
   logic                 queue_full, queue_empty;

   lpde_front #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   lpde_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   lpde_back #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line program delta encoder. Mapping requests go
// in through the request channel. A tracker keeps its own copy of the previous
// offsets and predicts the opcode and LEB128 bytes of each accepted request.
// Every response byte is checked against the oldest prediction. Directed
// corner mappings come first, then random ones, with random idle and stall
// bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
   import lpde_pkg::*;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] value;
      logic                  last;
   } program_byte_type;

   class line_program_tracker_type;
      logic [FIELD_WIDTH-1:0] last_source;
      logic [FIELD_WIDTH-1:0] last_dest;
      program_byte_type       pending_bytes[$];
      int unsigned            mismatches;

      function new();
         last_source = '0;
         last_dest   = '0;
         mismatches  = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void push_byte(logic [BYTE_WIDTH-1:0] value, logic last);
         program_byte_type entry;
         entry.value = value;
         entry.last  = last;
         pending_bytes = {pending_bytes, entry};
      endfunction

      function void push_unsigned_leb(logic [FIELD_WIDTH-1:0] delta);
         logic [FIELD_WIDTH-1:0] rest;
         logic [BYTE_WIDTH-1:0]  chunk;
         bit                     more;
         rest = delta;
         more = 1'b1;
         while (more) begin
            chunk = {1'b0, rest[LEB_DATA_BITS-1:0]};
            rest  = rest >> LEB_DATA_BITS;
            more  = (rest != '0);
            if (more) chunk[BYTE_WIDTH-1] = 1'b1;
            push_byte(chunk, 1'b0);
         end
      endfunction

      function void push_signed_leb(logic [FIELD_WIDTH-1:0] delta);
         logic signed [FIELD_WIDTH-1:0] rest;
         logic [BYTE_WIDTH-1:0]         chunk;
         bit                            more;
         rest = delta;
         more = 1'b1;
         while (more) begin
            chunk = {1'b0, rest[LEB_DATA_BITS-1:0]};
            rest  = rest >>> LEB_DATA_BITS;
            if ((rest == '0 && !chunk[6]) || (rest == '1 && chunk[6])) more = 1'b0;
            if (more) chunk[BYTE_WIDTH-1] = 1'b1;
            push_byte(chunk, 1'b0);
         end
      endfunction

      function void note_mapping(logic [FIELD_WIDTH-1:0] src, logic [FIELD_WIDTH-1:0] dst);
         if (dst != last_dest) begin
            push_byte(OP_ADVANCE_PC, 1'b0);
            push_unsigned_leb(dst - last_dest);
         end
         if (src != last_source) begin
            push_byte(OP_ADVANCE_LINE, 1'b0);
            push_signed_leb(src - last_source);
         end
         push_byte(OP_COPY, 1'b1);
         last_source = src;
         last_dest   = dst;
      endfunction

      task check_byte(logic [BYTE_WIDTH-1:0] value, logic last);
         program_byte_type want;
         if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %b", value, last));
         end else begin
            want = pending_bytes.pop_front();
            if (value !== want.value)
               report($sformatf("out_byte %02h, want %02h", value, want.value));
            if (last !== want.last)
               report($sformatf("last_byte %b, want %b", last, want.last));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   int   stall_left;

   line_program_tracker_type tracker;

   lpde_req_if req_bus ();
   lpde_rsp_if rsp_bus ();

   line_program_delta_encoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #600000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         tracker.check_byte(rsp_bus.out_byte, rsp_bus.last_byte);
   end

   task automatic send_mapping(input logic [FIELD_WIDTH-1:0] src,
                               input logic [FIELD_WIDTH-1:0] dst);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.source_offset = src;
      req_bus.dest_offset   = dst;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_mapping(src, dst);
   endtask

   task automatic send_random_mapping();
      logic [FIELD_WIDTH-1:0] src;
      logic [FIELD_WIDTH-1:0] dst;
      logic [FIELD_WIDTH-1:0] step;
      int unsigned            pick;
      src  = tracker.last_source;
      dst  = tracker.last_dest;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // hold both offsets
      end else if (pick <= 4) begin
         src = src + $urandom_range(0, 40) - 10;
         dst = dst + $urandom_range(1, 200);
      end else if (pick <= 6) begin
         step = $urandom >> $urandom_range(0, 31);
         src  = $urandom_range(0, 1) ? src + step : src - step;
         step = $urandom >> $urandom_range(0, 31);
         dst  = $urandom_range(0, 1) ? dst + step : dst - step;
      end else if (pick == 7) begin
         src = $urandom;
         dst = $urandom;
      end else if (pick == 8) begin
         step = $urandom >> $urandom_range(0, 31);
         src  = $urandom_range(0, 1) ? src + step : src - step;
      end else begin
         dst = dst + ($urandom >> $urandom_range(0, 31));
      end
      send_mapping(src, dst);
   endtask

   initial begin
      tracker               = new();
      quiet                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.source_offset = '0;
      req_bus.dest_offset   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_mapping(32'h0000_0000, 32'h0000_0000);
      send_mapping(32'h0000_0000, 32'h0000_0001);
      send_mapping(32'h0000_0001, 32'h0000_0001);
      send_mapping(32'h0000_0040, 32'h0000_0080);
      send_mapping(32'h0000_0080, 32'h0000_0100);
      send_mapping(32'h0000_0040, 32'h0000_0100);
      send_mapping(32'h0000_003F, 32'h0000_0100);
      send_mapping(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_mapping(32'h0000_0000, 32'h0000_0000);
      send_mapping(32'h8000_0000, 32'h8000_0000);
      send_mapping(32'h0000_0000, 32'h8000_0000);
      send_mapping(32'h7FFF_FFFF, 32'h0000_0000);
      send_mapping(32'h7FFF_FFBE, 32'h0000_007F);
      send_mapping(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_mapping(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_mapping(32'h0000_0000, 32'hFFFF_FFFF);
      send_mapping(32'hAAAA_AAAA, 32'h5555_5555);
      send_mapping(32'h5555_5555, 32'hAAAA_AAAA);
      send_mapping(32'h5555_5595, 32'hAAAA_AAAA);
      send_mapping(32'h5555_5555, 32'h2AAA_AAAA);

      for (int i = 0; i < 360; i++) begin
         quiet = (i >= 300);
         send_random_mapping();
      end
      @(negedge clock);
      req_bus.valid = 1'b0;

      while (tracker.pending_bytes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_bytes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
